// File: sv/pfd_pkg.sv
// Shared types and constants for the priority flood drain block.
package pfd_pkg;

   localparam int MaxWidthDefault = 64;
   localparam int MaxHeightDefault = 64;
   localparam int DensityBitsDefault = 16;

   localparam int DimBits = 11;
   localparam int LimitBits = 13;
   localparam int CoordBits = 6;
   localparam int DensBits = 16;

   localparam logic [6:0] GridWidthReset = 7'd64;
   localparam logic [6:0] GridHeightReset = 7'd64;
   localparam logic [LimitBits-1:0] DrainLimitReset = 13'd2457;

   typedef enum logic [1:0] {
      REQ_LOAD,
      REQ_START,
      REQ_DRAIN
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_DRAINED,
      ST_EMPTY,
      ST_LIMIT
   } status_type;

   typedef enum logic [1:0] {
      CSR_GRID_WIDTH,
      CSR_GRID_HEIGHT,
      CSR_DRAIN_LIMIT
   } csr_index_type;

   typedef struct packed {
      logic [DimBits-1:0]   eff_w;
      logic [DimBits-1:0]   eff_h;
      logic [LimitBits-1:0] limit;
   } cfg_type;

   typedef struct packed {
      status_type           status;
      logic [CoordBits-1:0] x;
      logic [CoordBits-1:0] y;
      logic [DensBits-1:0]  dens;
   } res_type;

endpackage

// File: sv/pfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/pfd_core.sv
// Flood sequencer: density, flag and heap memories with sift up and sift down.
module pfd_core #(
   parameter int MAX_WIDTH = pfd_pkg::MaxWidthDefault,
   parameter int MAX_HEIGHT = pfd_pkg::MaxHeightDefault,
   parameter int DENSITY_BITS = pfd_pkg::DensityBitsDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pfd_pkg::cfg_type                cfg,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [1:0]                      in_type,
   input  logic [pfd_pkg::CoordBits-1:0]   in_x,
   input  logic [pfd_pkg::CoordBits-1:0]   in_y,
   input  logic [pfd_pkg::DensBits-1:0]    in_dens,
   output logic                            res_valid,
   input  logic                            res_ready,
   output pfd_pkg::res_type                res
);
   import pfd_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int AB = XW + YW;
   localparam int GD = 1 << AB;
   localparam int AREA = MAX_WIDTH * MAX_HEIGHT;
   localparam int HB = $clog2(AREA);
   localparam int CB = $clog2(AREA + 1);
   localparam int DB = DENSITY_BITS;
   localparam int EW = DB + HB + AB;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_SCLR, S_P1, S_P2, S_DOWN, S_DL, S_DR, S_DCMP, S_DFIN,
      S_DDEN, S_NB, S_PRD, S_PCHK, S_UP, S_UPC, S_RES
   } state_type;

   state_type       state_ff;
   logic [CB-1:0]   cnt_ff;
   logic [HB-1:0]   seq_ff;
   logic [CB-1:0]   drn_ff;
   logic [HB-1:0]   idx_ff;
   logic [EW-1:0]   cur_ff, top_ff, lft_ff, rgt_ff;
   logic            rgt_ok_ff;
   logic [AB-1:0]   clr_ff;
   logic [AB-1:0]   pcell_ff;
   logic [2:0]      nb_ff;
   logic            drain_ff;
   res_type         res_ff;

   logic            hp_we, hp_re;
   logic [HB-1:0]   hp_wa, hp_ra;
   logic [EW-1:0]   hp_wd, hp_rd;
   logic            dn_we, dn_re;
   logic [AB-1:0]   dn_wa, dn_ra;
   logic [DB-1:0]   dn_wd, dn_rd;
   logic            fl_we, fl_re;
   logic [AB-1:0]   fl_wa, fl_ra;
   logic [1:0]      fl_wd, fl_rd;

   function automatic logic goes_first(input logic [EW-1:0] a, input logic [EW-1:0] b);
      logic [DB-1:0] ad, bd;
      logic [HB-1:0] as, bs;
      ad = a[EW-1 -: DB];
      bd = b[EW-1 -: DB];
      as = a[HB+AB-1 -: HB];
      bs = b[HB+AB-1 -: HB];
      return (ad < bd) || ((ad == bd) && (as > bs));
   endfunction

   logic [31:0]     ld_x, ld_y, ld_d;
   logic            ld_in;
   logic [AB-1:0]   ld_addr;
   logic            accept;
   logic [HB+1:0]   lx, rx, cntx;
   logic            l_in, r_in;
   logic [HB-1:0]   par;
   logic [AB-1:0]   tcell;
   logic [XW-1:0]   tx;
   logic [YW-1:0]   ty;
   logic [XW:0]     eff_w;
   logic [YW:0]     eff_h;
   logic            nb_ok;
   logic [AB-1:0]   nb_cell;
   logic            pick_l, pick_r;
   logic [EW-1:0]   best;
   logic            up_swap;
   logic [31:0]     o_x, o_y, o_d;
   logic [AB-1:0]   seed;

   always_comb begin
      ld_x = 32'(in_x);
      ld_y = 32'(in_y);
      ld_d = 32'(in_dens);
      ld_in = (ld_x < 32'(MAX_WIDTH)) && (ld_y < 32'(MAX_HEIGHT));
      ld_addr = {ld_y[YW-1:0], ld_x[XW-1:0]};
      accept = in_valid && in_ready;
      lx = (HB+2)'({idx_ff, 1'b1});
      rx = lx + (HB+2)'(1);
      cntx = (HB+2)'(cnt_ff);
      l_in = lx < cntx;
      r_in = rx < cntx;
      par = (idx_ff - HB'(1)) >> 1;
      tcell = top_ff[AB-1:0];
      tx = tcell[XW-1:0];
      ty = tcell[AB-1:XW];
      eff_w = cfg.eff_w[XW:0];
      eff_h = cfg.eff_h[YW:0];
      seed = {{YW{1'b0}}, XW'(eff_w >> 1)};
      pick_l = goes_first(lft_ff, cur_ff);
      best = pick_l ? lft_ff : cur_ff;
      pick_r = rgt_ok_ff && goes_first(rgt_ff, best);
      up_swap = goes_first(cur_ff, hp_rd);
      o_x = 32'(tx);
      o_y = 32'(ty);
      o_d = 32'(dn_rd);
      nb_ok = 1'b0;
      nb_cell = tcell;
      case (nb_ff)
         3'd0: begin
            nb_ok = tx != '0;
            nb_cell = {ty, tx - XW'(1)};
         end
         3'd1: begin
            nb_ok = ((XW+1)'(tx) + (XW+1)'(1)) < eff_w;
            nb_cell = {ty, tx + XW'(1)};
         end
         3'd2: begin
            nb_ok = ty != '0;
            nb_cell = {ty - YW'(1), tx};
         end
         3'd3: begin
            nb_ok = ((YW+1)'(ty) + (YW+1)'(1)) < eff_h;
            nb_cell = {ty + YW'(1), tx};
         end
         default: begin
            nb_ok = 1'b0;
            nb_cell = tcell;
         end
      endcase
   end

   // memory control
   always_comb begin
      hp_we = 1'b0; hp_re = 1'b0; hp_wa = idx_ff; hp_ra = '0; hp_wd = cur_ff;
      dn_we = 1'b0; dn_re = 1'b0; dn_wa = ld_addr; dn_ra = tcell; dn_wd = ld_d[DB-1:0];
      fl_we = 1'b0; fl_re = 1'b0; fl_wa = clr_ff; fl_ra = pcell_ff; fl_wd = 2'b00;
      case (state_ff)
         S_INIT, S_SCLR: begin
            fl_we = 1'b1;
         end
         S_IDLE: begin
            if (accept && in_type == REQ_LOAD && ld_in) begin
               dn_we = 1'b1;
            end
            hp_re = accept && in_type == REQ_DRAIN;
         end
         S_P1: begin
            hp_re = 1'b1;
            hp_ra = HB'(cnt_ff - CB'(1));
         end
         S_DOWN: begin
            if (l_in) begin
               hp_re = 1'b1;
               hp_ra = HB'(lx);
            end else begin
               hp_we = 1'b1;
            end
         end
         S_DL: begin
            hp_re = r_in;
            hp_ra = HB'(rx);
         end
         S_DCMP: begin
            hp_we = 1'b1;
            hp_wd = pick_r ? rgt_ff : (pick_l ? lft_ff : cur_ff);
         end
         S_DFIN: begin
            dn_re = 1'b1;
         end
         S_DDEN: begin
            dn_we = 1'b1;
            dn_wa = tcell;
            dn_wd = '0;
            fl_we = 1'b1;
            fl_wa = tcell;
            fl_wd = 2'b11;
         end
         S_PRD: begin
            fl_re = 1'b1;
            dn_re = 1'b1;
            dn_ra = pcell_ff;
         end
         S_PCHK: begin
            fl_we = !fl_rd[1];
            fl_wa = pcell_ff;
            fl_wd = fl_rd | 2'b10;
         end
         S_UP: begin
            if (idx_ff == '0) begin
               hp_we = 1'b1;
            end else begin
               hp_re = 1'b1;
               hp_ra = par;
            end
         end
         S_UPC: begin
            hp_we = 1'b1;
            hp_wd = up_swap ? hp_rd : cur_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         clr_ff <= '0;
         cnt_ff <= '0;
         seq_ff <= '0;
         drn_ff <= '0;
         drain_ff <= 1'b0;
         nb_ff <= '0;
      end else begin
         case (state_ff)
            S_INIT: begin
               clr_ff <= clr_ff + AB'(1);
               if (clr_ff == AB'(GD - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (accept) begin
                  case (in_type)
                     REQ_START: begin
                        res_ff <= '{ST_OK, '0, '0, '0};
                        clr_ff <= '0;
                        state_ff <= S_SCLR;
                     end
                     REQ_DRAIN: begin
                        if (32'(drn_ff) >= 32'(cfg.limit)) begin
                           res_ff <= '{ST_LIMIT, '0, '0, '0};
                           state_ff <= S_RES;
                        end else if (cnt_ff == '0) begin
                           res_ff <= '{ST_EMPTY, '0, '0, '0};
                           state_ff <= S_RES;
                        end else begin
                           res_ff <= '{ST_OK, '0, '0, '0};
                           drain_ff <= 1'b1;
                           state_ff <= S_P1;
                        end
                     end
                     default: begin
                        res_ff <= '{ST_OK, '0, '0, '0};
                        state_ff <= S_RES;
                     end
                  endcase
               end
            end
            S_SCLR: begin
               clr_ff <= clr_ff + AB'(1);
               if (clr_ff == AB'(GD - 1)) begin
                  cnt_ff <= '0;
                  seq_ff <= '0;
                  drn_ff <= '0;
                  drain_ff <= 1'b0;
                  pcell_ff <= seed;
                  state_ff <= S_PRD;
               end
            end
            S_P1: begin
               top_ff <= hp_rd;
               cnt_ff <= cnt_ff - CB'(1);
               state_ff <= S_P2;
            end
            S_P2: begin
               cur_ff <= hp_rd;
               idx_ff <= '0;
               state_ff <= S_DOWN;
            end
            S_DOWN: begin
               state_ff <= l_in ? S_DL : S_DFIN;
            end
            S_DL: begin
               lft_ff <= hp_rd;
               rgt_ok_ff <= r_in;
               state_ff <= r_in ? S_DR : S_DCMP;
            end
            S_DR: begin
               rgt_ff <= hp_rd;
               state_ff <= S_DCMP;
            end
            S_DCMP: begin
               if (pick_r) begin
                  idx_ff <= HB'(rx);
                  state_ff <= S_DOWN;
               end else if (pick_l) begin
                  idx_ff <= HB'(lx);
                  state_ff <= S_DOWN;
               end else begin
                  state_ff <= S_DFIN;
               end
            end
            S_DFIN: begin
               state_ff <= S_DDEN;
            end
            S_DDEN: begin
               res_ff.status <= ST_DRAINED;
               res_ff.x <= o_x[CoordBits-1:0];
               res_ff.y <= o_y[CoordBits-1:0];
               res_ff.dens <= o_d[DensBits-1:0];
               drn_ff <= drn_ff + CB'(1);
               nb_ff <= '0;
               state_ff <= S_NB;
            end
            S_NB: begin
               if (nb_ff == 3'd4) begin
                  drain_ff <= 1'b0;
                  state_ff <= S_RES;
               end else if (nb_ok) begin
                  pcell_ff <= nb_cell;
                  state_ff <= S_PRD;
               end else begin
                  nb_ff <= nb_ff + 3'd1;
               end
            end
            S_PRD: begin
               state_ff <= S_PCHK;
            end
            S_PCHK: begin
               if (fl_rd[1] || cnt_ff == CB'(AREA)) begin
                  nb_ff <= nb_ff + 3'd1;
                  state_ff <= drain_ff ? S_NB : S_RES;
               end else begin
                  cur_ff <= {dn_rd, seq_ff, pcell_ff};
                  seq_ff <= seq_ff + HB'(1);
                  idx_ff <= HB'(cnt_ff);
                  cnt_ff <= cnt_ff + CB'(1);
                  state_ff <= S_UP;
               end
            end
            S_UP: begin
               if (idx_ff == '0) begin
                  nb_ff <= nb_ff + 3'd1;
                  state_ff <= drain_ff ? S_NB : S_RES;
               end else begin
                  state_ff <= S_UPC;
               end
            end
            S_UPC: begin
               if (up_swap) begin
                  idx_ff <= par;
                  state_ff <= S_UP;
               end else begin
                  nb_ff <= nb_ff + 3'd1;
                  state_ff <= drain_ff ? S_NB : S_RES;
               end
            end
            S_RES: begin
               if (res_ready) state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign in_ready = state_ff == S_IDLE;
   assign res_valid = state_ff == S_RES;
   assign res = res_ff;

   pfd_ram #(.WIDTH(DB), .DEPTH(GD)) u_dens (
      .clock(clock), .wr_en(dn_we), .wr_addr(dn_wa), .wr_data(dn_wd),
      .rd_en(dn_re), .rd_addr(dn_ra), .rd_data(dn_rd)
   );

   pfd_ram #(.WIDTH(2), .DEPTH(GD)) u_flags (
      .clock(clock), .wr_en(fl_we), .wr_addr(fl_wa), .wr_data(fl_wd),
      .rd_en(fl_re), .rd_addr(fl_ra), .rd_data(fl_rd)
   );

   pfd_ram #(.WIDTH(EW), .DEPTH(AREA)) u_heap (
      .clock(clock), .wr_en(hp_we), .wr_addr(hp_wa), .wr_data(hp_wd),
      .rd_en(hp_re), .rd_addr(hp_ra), .rd_data(hp_rd)
   );

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CB'(AREA))
      else $error("frontier count beyond heap depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_P1 |-> cnt_ff != '0)
      else $error("pop from empty frontier");

   a_heap_no_rw_same: assert property (@(posedge clock) disable iff (reset)
      !(hp_we && hp_re && hp_wa == hp_ra))
      else $error("heap read and write on same entry");

   a_drain_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DDEN |=> drn_ff == $past(drn_ff) + CB'(1))
      else $error("drained count did not advance");

endmodule

// File: sv/priority_flood_drain.sv
// Top level: stream ports, configuration registers, result register.
// Load or out-of-range request goes straight to the result; start runs the flag sweep, then seeds the frontier.
// Drain: a pop with sift down over the heap levels, plus up to 4 pushes with sift up;
// the single read port of the heap memory paces each sift step.
// One item in flight; the next is taken while the previous result waits at rsp.
// Reset: synchronous; registers to their defaults, then a sweep that clears every flag entry with req_tready low.
module priority_flood_drain #(
   parameter int MAX_WIDTH = pfd_pkg::MaxWidthDefault,
   parameter int MAX_HEIGHT = pfd_pkg::MaxHeightDefault,
   parameter int DENSITY_BITS = pfd_pkg::DensityBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // cell_x, cell_y, cell_density, zero pad
   input  logic [1:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // drained_x, drained_y, drained_density, zero pad
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);
   import pfd_pkg::*;

   logic [6:0]           grid_width_ff, grid_height_ff;
   logic [LimitBits-1:0] drain_limit_ff;
   cfg_type              cfg;
   logic [DimBits-1:0]   w_raw, h_raw;
   logic                 res_valid, res_ready;
   res_type              res;
   logic                 rsp_valid_ff;
   res_type              rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= GridWidthReset;
         grid_height_ff <= GridHeightReset;
         drain_limit_ff <= DrainLimitReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GRID_WIDTH: grid_width_ff <= csr_data[6:0];
            CSR_GRID_HEIGHT: grid_height_ff <= csr_data[6:0];
            CSR_DRAIN_LIMIT: drain_limit_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      w_raw = DimBits'(grid_width_ff);
      h_raw = DimBits'(grid_height_ff);
      cfg.eff_w = (w_raw == '0) ? DimBits'(1) :
                  (w_raw > DimBits'(MAX_WIDTH)) ? DimBits'(MAX_WIDTH) : w_raw;
      cfg.eff_h = (h_raw == '0) ? DimBits'(1) :
                  (h_raw > DimBits'(MAX_HEIGHT)) ? DimBits'(MAX_HEIGHT) : h_raw;
      cfg.limit = drain_limit_ff;
   end

   assign csr_ready = 1'b1;

   pfd_core #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .DENSITY_BITS(DENSITY_BITS)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_type(req_tuser),
      .in_x(req_tdata[5:0]),
      .in_y(req_tdata[11:6]),
      .in_dens(req_tdata[27:12]),
      .res_valid(res_valid),
      .res_ready(res_ready),
      .res(res)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
         rsp_word_ff <= res;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_word_ff.status;
   assign rsp_tdata = {4'b0000, rsp_word_ff.dens, rsp_word_ff.y, rsp_word_ff.x};

endmodule
